// ===== design/flpr_pkg.sv =====
// ----------------------------------------------------------------------------
// flpr_pkg
// Shared types, constants and helpers for the page replacement tracker.
// ----------------------------------------------------------------------------
package flpr_pkg;

  localparam int MAX_FRAMES  = 16;
  localparam int PAGE_WIDTH  = 8;
  localparam int SLOT_W      = 4;
  localparam int RANK_W      = 4;
  localparam int FCNT_W      = 5;
  localparam int CNT_W       = 16;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  typedef enum logic {
    REG_POLICY_LRU    = 1'b0,
    REG_FRAMES_IN_USE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PAGE_WIDTH-1:0] page_number;
    logic                  is_write;
  } in_t;

  typedef struct packed {
    logic                  fault;
    logic [SLOT_W-1:0]     slot;
    logic                  evicted_valid;
    logic [PAGE_WIDTH-1:0] evicted_page;
    logic [CNT_W-1:0]      fault_count;
    logic [CNT_W-1:0]      write_count;
  } out_t;

  typedef struct packed {
    logic              policy_lru;
    logic [FCNT_W-1:0] frames_in_use;
  } cfg_t;

  function automatic logic [SLOT_W-1:0] lowest_set(input logic [MAX_FRAMES-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== design/fifo_lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// fifo_lru_page_replacement
// Page reference tracker with FIFO or LRU replacement over a register table.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_item and raise start; a transaction is taken at a rising
//   edge with start high and busy low. busy is low except as noted under Reset
//   below, so one reference can be issued every cycle.
//   Output: out_strobe is high for exactly one cycle with out_item holding
//   hit/fault, slot, evicted page and the running fault and write counts.
//   The accepted reference is registered in item_r, and its result in
//   out_item_r; throughput is one reference per cycle, set by the single
//   compare/select pass over the 16 frame registers.
//   Config: APB port, register 0 (policy_lru) at 0x0, register 1
//   (frames_in_use) at 0x4; write only while no transaction is in flight.
//   Reset (rst_n low, synchronous) empties the table, clears ranks, FIFO
//   pointer and counters, and restores FIFO policy with 4 frames. busy is
//   high during reset and for one cycle after it.
//   The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module fifo_lru_page_replacement (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  flpr_pkg::in_t                 in_item,
  output logic                          out_strobe,
  output flpr_pkg::out_t                out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [flpr_pkg::APB_AW-1:0]   paddr,
  input  logic [flpr_pkg::APB_DW-1:0]   pwdata,
  output logic [flpr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  flpr_pkg::cfg_t cfg_r;
  flpr_pkg::in_t  item_r;
  flpr_pkg::out_t result;
  logic           item_vld_r;
  logic           busy_r;
  logic           out_strobe_r;
  flpr_pkg::out_t out_item_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign busy   = busy_r || !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy_lru    <= 1'b0;
      cfg_r.frames_in_use <= flpr_pkg::FCNT_W'(4);
    end else if (wr_en) begin
      case (flpr_pkg::reg_idx_t'(paddr[2]))
        flpr_pkg::REG_POLICY_LRU:    cfg_r.policy_lru    <= pwdata[0];
        flpr_pkg::REG_FRAMES_IN_USE: cfg_r.frames_in_use <= pwdata[flpr_pkg::FCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (flpr_pkg::reg_idx_t'(paddr[2]))
      flpr_pkg::REG_POLICY_LRU:    prdata = flpr_pkg::APB_DW'(cfg_r.policy_lru);
      flpr_pkg::REG_FRAMES_IN_USE: prdata = flpr_pkg::APB_DW'(cfg_r.frames_in_use);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      item_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      item_vld_r   <= start && !busy;
      out_strobe_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) item_r <= in_item;
    if (item_vld_r)     out_item_r <= result;
  end

  flpr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld_r),
    .item     (item_r),
    .cfg      (cfg_r),
    .result   (result)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ===== design/flpr_core.sv =====
// ----------------------------------------------------------------------------
// flpr_core
// Frame table with parallel lookup, fill, FIFO/LRU victim select and counters.
// ----------------------------------------------------------------------------
module flpr_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_vld,
  input  flpr_pkg::in_t  item,
  input  flpr_pkg::cfg_t cfg,
  output flpr_pkg::out_t result
);

  logic [flpr_pkg::PAGE_WIDTH-1:0] page_r  [flpr_pkg::MAX_FRAMES];
  logic [flpr_pkg::RANK_W-1:0]     rank_r  [flpr_pkg::MAX_FRAMES];
  logic [flpr_pkg::RANK_W-1:0]     rank_nxt[flpr_pkg::MAX_FRAMES];
  logic [flpr_pkg::MAX_FRAMES-1:0] valid_r;
  logic [flpr_pkg::SLOT_W-1:0]     ptr_r, ptr_nxt, ptr_use;
  logic [flpr_pkg::CNT_W-1:0]      faults_r, faults_nxt;
  logic [flpr_pkg::CNT_W-1:0]      writes_r, writes_nxt;

  logic [flpr_pkg::FCNT_W-1:0]     f_eff;
  logic [flpr_pkg::FCNT_W-1:0]     ptr_inc;
  logic [flpr_pkg::MAX_FRAMES-1:0] in_use, hit_vec, empty_vec, max_vec;
  logic                            hit, empty_any, evict;
  logic [flpr_pkg::SLOT_W-1:0]     slot;
  logic [flpr_pkg::RANK_W:0]       old_rank;

  always_comb begin
    if (cfg.frames_in_use == '0) begin
      f_eff = flpr_pkg::FCNT_W'(1);
    end else if (cfg.frames_in_use > flpr_pkg::FCNT_W'(flpr_pkg::MAX_FRAMES)) begin
      f_eff = flpr_pkg::FCNT_W'(flpr_pkg::MAX_FRAMES);
    end else begin
      f_eff = cfg.frames_in_use;
    end
  end

  always_comb begin
    for (int j = 0; j < flpr_pkg::MAX_FRAMES; j++) begin
      in_use[j]    = flpr_pkg::FCNT_W'(j) < f_eff;
      hit_vec[j]   = in_use[j] && valid_r[j] && (page_r[j] == item.page_number);
      empty_vec[j] = in_use[j] && !valid_r[j];
    end
  end

  // oldest frame: strictly older than lower frames, at least as old as higher ones
  always_comb begin
    for (int j = 0; j < flpr_pkg::MAX_FRAMES; j++) begin
      max_vec[j] = in_use[j];
      for (int k = 0; k < flpr_pkg::MAX_FRAMES; k++) begin
        if (in_use[k] && k < j && rank_r[k] >= rank_r[j]) max_vec[j] = 1'b0;
        if (in_use[k] && k > j && rank_r[k] > rank_r[j])  max_vec[j] = 1'b0;
      end
    end
  end

  assign ptr_use = ({1'b0, ptr_r} >= f_eff) ? '0 : ptr_r;
  assign ptr_inc = {1'b0, ptr_use} + flpr_pkg::FCNT_W'(1);

  assign hit       = |hit_vec;
  assign empty_any = |empty_vec;
  assign evict     = !hit && !empty_any;

  always_comb begin
    if (hit) begin
      slot = flpr_pkg::lowest_set(hit_vec);
    end else if (empty_any) begin
      slot = flpr_pkg::lowest_set(empty_vec);
    end else if (cfg.policy_lru) begin
      slot = flpr_pkg::lowest_set(max_vec);
    end else begin
      slot = ptr_use;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (evict && !cfg.policy_lru) begin
      ptr_nxt = (ptr_inc >= f_eff) ? '0 : ptr_inc[flpr_pkg::SLOT_W-1:0];
    end
  end

  always_comb begin
    old_rank = hit ? {1'b0, rank_r[slot]} : {1'b1, {flpr_pkg::RANK_W{1'b0}}};
    for (int j = 0; j < flpr_pkg::MAX_FRAMES; j++) begin
      rank_nxt[j] = rank_r[j];
      if (flpr_pkg::SLOT_W'(j) == slot) begin
        rank_nxt[j] = '0;
      end else if (in_use[j] && valid_r[j] && ({1'b0, rank_r[j]} < old_rank)
                   && rank_r[j] != flpr_pkg::RANK_MAX) begin
        rank_nxt[j] = rank_r[j] + flpr_pkg::RANK_W'(1);
      end
    end
  end

  assign writes_nxt = (item.is_write && writes_r != flpr_pkg::CNT_MAX) ?
                      writes_r + flpr_pkg::CNT_W'(1) : writes_r;
  assign faults_nxt = (!hit && faults_r != flpr_pkg::CNT_MAX) ?
                      faults_r + flpr_pkg::CNT_W'(1) : faults_r;

  always_comb begin
    result.fault         = !hit;
    result.slot          = slot;
    result.evicted_valid = evict;
    result.evicted_page  = evict ? page_r[slot] : '0;
    result.fault_count   = faults_nxt;
    result.write_count   = writes_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      ptr_r    <= '0;
      faults_r <= '0;
      writes_r <= '0;
      for (int j = 0; j < flpr_pkg::MAX_FRAMES; j++) rank_r[j] <= '0;
    end else if (item_vld) begin
      ptr_r    <= ptr_nxt;
      faults_r <= faults_nxt;
      writes_r <= writes_nxt;
      for (int j = 0; j < flpr_pkg::MAX_FRAMES; j++) rank_r[j] <= rank_nxt[j];
      if (!hit) valid_r[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_vld && !hit) page_r[slot] <= item.page_number;
  end

endmodule

// ===== design/flpr_checker.sv =====
// ----------------------------------------------------------------------------
// flpr_checker
// Port-level checks for the page replacement tracker, bound to the top level.
// ----------------------------------------------------------------------------
module flpr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input flpr_pkg::out_t              out_item
);

  logic acc;
  assign acc = start && !busy;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> ##1 out_strobe)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc, 2))
    else $error("result without accepted transaction");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.evicted_valid |-> out_item.evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.evicted_valid |-> out_item.fault)
    else $error("eviction on a hit");

  a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(out_strobe) && out_item.fault
      && $past(out_item.fault_count) != flpr_pkg::CNT_MAX
      |-> out_item.fault_count == flpr_pkg::CNT_W'($past(out_item.fault_count) + 1))
    else $error("fault count did not advance");

endmodule

bind fifo_lru_page_replacement flpr_checker u_flpr_checker (.*);
